// ----- design/ealu_pkg.sv -----
`default_nettype none

package ealu_pkg;

    typedef enum logic [3:0] {
        ACT_ADD  = 4'd0,
        ACT_ADC  = 4'd1,
        ACT_SUB  = 4'd2,
        ACT_SBC  = 4'd3,
        ACT_AND  = 4'd4,
        ACT_XOR  = 4'd5,
        ACT_OR   = 4'd6,
        ACT_CP   = 4'd7,
        ACT_INC  = 4'd8,
        ACT_DEC  = 4'd9,
        ACT_RLCA = 4'd10,
        ACT_RLC  = 4'd11,
        ACT_SLA  = 4'd12,
        ACT_SRA  = 4'd13,
        ACT_SWAP = 4'd14,
        ACT_CPL  = 4'd15
    } action_t;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        action_t    action;
        logic [7:0] accumulator;
        logic [7:0] operand;
        logic [3:0] flags_in;
    } op_t;

    typedef struct packed {
        logic [7:0] result;
        logic [3:0] flags_out;
    } res_t;

endpackage

`default_nettype wire

// ----- design/ealu_in_reg.sv -----
`default_nettype none

module ealu_in_reg (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             in_valid,
    output logic            in_ready,
    input  wire ealu_pkg::op_t in_op,
    output logic            op_valid,
    input  wire             op_ready,
    output ealu_pkg::op_t   op
);
    import ealu_pkg::*;

    logic valid_reg;
    logic valid_next;
    op_t  op_reg;

    assign in_ready = !valid_reg || op_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload loads whenever the stage takes an item
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            op_reg <= in_op;
        end
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;

endmodule

`default_nettype wire

// ----- design/ealu_core.sv -----
`default_nettype none

module ealu_core (
    input  wire ealu_pkg::op_t op,
    output ealu_pkg::res_t res
);
    import ealu_pkg::*;

    logic [7:0] a;
    logic [7:0] b;
    logic       cin;
    logic       cy;
    logic [8:0] sum9;
    logic [4:0] sum_lo;
    logic [8:0] diff9;
    logic [4:0] diff_lo;
    logic [7:0] r;
    logic [3:0] f;

    assign a   = op.accumulator;
    assign b   = op.operand;
    assign cin = op.flags_in[FLAG_C];
    assign cy  = ((op.action == ACT_ADC) || (op.action == ACT_SBC)) ? cin : 1'b0;

    // borrow shows up as the sign bit of the widened difference
    assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, cy};
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
    assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, cy};
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};

    always_comb begin
        r = a;
        f = 4'd0;
        case (op.action)
            ACT_ADD, ACT_ADC: begin
                r         = sum9[7:0];
                f[FLAG_H] = sum_lo[4];
                f[FLAG_C] = sum9[8];
                f[FLAG_Z] = (sum9[7:0] == 8'd0);
            end
            ACT_SUB, ACT_SBC, ACT_CP: begin
                r         = (op.action == ACT_CP) ? a : diff9[7:0];
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = diff_lo[4];
                f[FLAG_C] = diff9[8];
                f[FLAG_Z] = (diff9[7:0] == 8'd0);
            end
            ACT_AND: begin
                r         = a & b;
                f[FLAG_H] = 1'b1;
                f[FLAG_Z] = ((a & b) == 8'd0);
            end
            ACT_XOR: begin
                r         = a ^ b;
                f[FLAG_Z] = ((a ^ b) == 8'd0);
            end
            ACT_OR: begin
                r         = a | b;
                f[FLAG_Z] = ((a | b) == 8'd0);
            end
            ACT_INC: begin
                r         = a + 8'd1;
                f[FLAG_Z] = (a == 8'hFF);
                f[FLAG_H] = (a[3:0] == 4'hF);
                f[FLAG_C] = cin;
            end
            ACT_DEC: begin
                r         = a - 8'd1;
                f[FLAG_Z] = (a == 8'd1);
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = (a[3:0] == 4'h0);
                f[FLAG_C] = cin;
            end
            ACT_RLCA: begin
                r         = {a[6:0], a[7]};
                f[FLAG_C] = a[7];
            end
            ACT_RLC: begin
                r         = {a[6:0], a[7]};
                f[FLAG_C] = a[7];
                f[FLAG_Z] = (a == 8'd0);
            end
            ACT_SLA: begin
                r         = {a[6:0], 1'b0};
                f[FLAG_C] = a[7];
                f[FLAG_Z] = (a[6:0] == 7'd0);
            end
            ACT_SRA: begin
                r         = {a[7], a[7:1]};
                f[FLAG_C] = a[0];
                f[FLAG_Z] = (a[7:1] == 7'd0);
            end
            ACT_SWAP: begin
                r         = {a[3:0], a[7:4]};
                f[FLAG_Z] = (a == 8'd0);
            end
            ACT_CPL: begin
                r         = ~a;
                f[FLAG_Z] = op.flags_in[FLAG_Z];
                f[FLAG_C] = cin;
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = 1'b1;
            end
            default: begin
                r = a;
                f = 4'd0;
            end
        endcase
    end

    assign res.result    = r;
    assign res.flags_out = f;

endmodule

`default_nettype wire

// ----- design/ealu_out_reg.sv -----
`default_nettype none

module ealu_out_reg (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             res_valid,
    output logic            res_ready,
    input  wire ealu_pkg::res_t res,
    output logic            out_valid,
    input  wire             out_ready,
    output ealu_pkg::res_t  out_res
);
    import ealu_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign res_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_ready) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // hold the result while the sink stalls
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ----- design/eight_bit_alu_with_flags.sv -----
// Accept to result valid: input register, ALU (8-bit add/subtract, flags), result register.
// Throughput: one item per cycle unless m_ready stalls; the ALU sits in one stage.
// Backpressure from m_ready stalls both register stages; s_ready stays high while a
// stage is free.
// Reset: aresetn synchronous, active low; clears both stage valid bits, no items kept.
`default_nettype none

module eight_bit_alu_with_flags (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [3:0]  s_action,
    input  wire  [7:0]  s_accumulator,
    input  wire  [7:0]  s_operand,
    input  wire  [3:0]  s_flags_in,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_result,
    output logic [3:0]  m_flags_out
);
    import ealu_pkg::*;

    op_t  in_op;
    op_t  op;
    logic op_valid;
    logic op_ready;
    res_t res;
    res_t out_res;

    assign in_op.action      = action_t'(s_action);
    assign in_op.accumulator = s_accumulator;
    assign in_op.operand     = s_operand;
    assign in_op.flags_in    = s_flags_in;

    ealu_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_op    (in_op),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    ealu_core u_core (
        .op  (op),
        .res (res)
    );

    ealu_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (op_valid),
        .res_ready (op_ready),
        .res       (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_result    = out_res.result;
    assign m_flags_out = out_res.flags_out;

endmodule

`default_nettype wire

// ----- design/ealu_checker.sv -----
`default_nettype none

module ealu_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire [3:0] s_action,
    input wire [7:0] s_accumulator,
    input wire [7:0] s_operand,
    input wire [3:0] s_flags_in,
    input wire       m_valid,
    input wire       m_ready,
    input wire [7:0] m_result,
    input wire [3:0] m_flags_out
);

    // reset drops any item in flight
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // after an accept, the output must show that item or an older one
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##2 m_valid)
        else $error("no result two cycles after accept");

    // input backpressure only when the pipe is full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with empty output");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_result) && $stable(m_flags_out)))
        else $error("stalled result changed");

endmodule

bind eight_bit_alu_with_flags ealu_checker u_ealu_checker (.*);

`default_nettype wire
